// File: rtl/brs_pkg.sv
// brs_pkg: types, codes and shared helpers for the brent root search engine
// no dependencies; imported by every module of the block
package brs_pkg;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_SWAP, S_CHECK,
      S_IQ_D1, S_IQ_W1, S_IQ_D2, S_IQ_W2,
      S_IQ_M1, S_IQ_M2, S_IQ_M3, S_IQ_M4, S_IQ_END,
      S_SEC_M1, S_SEC_M2, S_SEC_D, S_SEC_W,
      S_DECIDE, S_EMIT
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CAPTURE, OP_LOAD, OP_SWAP, OP_CHECK,
      OP_DIV_IQ1, OP_DIV_IQ2, OP_DIV_SEC,
      OP_WB_T1, OP_WB_T2, OP_WB_S,
      OP_MUL_T, OP_MUL_X, OP_MUL_AFB, OP_MUL_BFA,
      OP_MUL_WB, OP_ACC, OP_IQ_DONE, OP_DECIDE, OP_EMIT
   } op_type;

   localparam logic [1:0] KIND_QUERY = 2'd0;
   localparam logic [1:0] KIND_ROOT  = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic MODE_START = 1'b0;
   localparam logic MODE_VALUE = 1'b1;

   localparam logic [1:0] TERM_LAST = 2'd2;
   localparam logic [30:0] TOL_RESET = 31'd66;

   localparam logic signed [65:0] SAT_MAX = 66'sd2147483647;
   localparam logic signed [65:0] SAT_MIN = -66'sd2147483648;

   typedef struct packed {
      op_type     op;
      logic [1:0] term;
   } cmd_type;

   typedef struct packed {
      logic bad_item;
      logic done_now;
      logic iq_ok;
      logic sec_ok;
      logic div_done;
      logic slot_free;
   } status_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > SAT_MAX) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < SAT_MIN) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

// File: rtl/brs_div.sv
// brs_div: restoring divider, one quotient bit per cycle, truncating, saturated result
// depends on brs_pkg
module brs_div
   import brs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [64:0] num,
   input  logic signed [32:0] den,
   output logic               done,
   output logic signed [31:0] quot
);

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [32:0] rem_ff;
   logic [63:0] quo_ff;
   logic [32:0] den_ff;
   logic        neg_ff;

   logic [64:0] num_mag;
   logic [32:0] den_mag;
   logic [33:0] trial;
   logic        fits;
   logic signed [65:0] q_full;

   always_comb begin
      num_mag = num[64] ? 65'(-num) : 65'(num);
      den_mag = den[32] ? 33'(-den) : 33'(den);
      trial   = {rem_ff, quo_ff[63]};
      fits    = trial >= {1'b0, den_ff};
      q_full  = neg_ff ? -$signed({2'b00, quo_ff}) : $signed({2'b00, quo_ff});
   end

   assign done = done_ff;
   assign quot = sat32(q_full);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         cnt_ff <= cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num_mag[63:0];
         den_ff <= den_mag;
         neg_ff <= num[64] ^ den[32];
      end else if (busy_ff) begin
         rem_ff <= fits ? 33'(trial - {1'b0, den_ff}) : trial[32:0];
         quo_ff <= {quo_ff[62:0], fits};
      end
   end

endmodule

// File: rtl/brs_ctrl.sv
// brs_ctrl: sequencer for one search step, drives the datapath by commands
// depends on brs_pkg
module brs_ctrl
   import brs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type  state_ff, state_in;
   logic [1:0] term_ff, term_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         term_ff  <= '0;
      end else begin
         state_ff <= state_in;
         term_ff  <= term_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      term_in = term_ff;
      if (state_ff == S_CHECK) begin
         term_in = '0;
      end else if (state_ff == S_IQ_M4 && term_ff != TERM_LAST) begin
         term_in = term_ff + 2'd1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (req_valid) state_in = S_LOAD;
         S_LOAD:   state_in = status.bad_item ? S_EMIT : S_SWAP;
         S_SWAP:   state_in = S_CHECK;
         S_CHECK: begin
            if (status.done_now)    state_in = S_EMIT;
            else if (status.iq_ok)  state_in = S_IQ_D1;
            else if (status.sec_ok) state_in = S_SEC_M1;
            else                    state_in = S_DECIDE;
         end
         S_IQ_D1:  state_in = S_IQ_W1;
         S_IQ_W1:  if (status.div_done) state_in = S_IQ_D2;
         S_IQ_D2:  state_in = S_IQ_W2;
         S_IQ_W2:  if (status.div_done) state_in = S_IQ_M1;
         S_IQ_M1:  state_in = S_IQ_M2;
         S_IQ_M2:  state_in = S_IQ_M3;
         S_IQ_M3:  state_in = S_IQ_M4;
         S_IQ_M4:  state_in = (term_ff == TERM_LAST) ? S_IQ_END : S_IQ_D1;
         S_IQ_END: state_in = S_DECIDE;
         S_SEC_M1: state_in = S_SEC_M2;
         S_SEC_M2: state_in = S_SEC_D;
         S_SEC_D:  state_in = S_SEC_W;
         S_SEC_W:  if (status.div_done) state_in = S_DECIDE;
         S_DECIDE: state_in = S_EMIT;
         S_EMIT:   if (status.slot_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.term = term_ff;
      cmd.op   = OP_NONE;
      unique case (state_ff)
         S_IDLE:   cmd.op = req_valid ? OP_CAPTURE : OP_NONE;
         S_LOAD:   cmd.op = OP_LOAD;
         S_SWAP:   cmd.op = OP_SWAP;
         S_CHECK:  cmd.op = OP_CHECK;
         S_IQ_D1:  cmd.op = OP_DIV_IQ1;
         S_IQ_W1:  cmd.op = OP_WB_T1;
         S_IQ_D2:  cmd.op = OP_DIV_IQ2;
         S_IQ_W2:  cmd.op = OP_WB_T2;
         S_IQ_M1:  cmd.op = OP_MUL_T;
         S_IQ_M2:  cmd.op = OP_MUL_WB;
         S_IQ_M3:  cmd.op = OP_MUL_X;
         S_IQ_M4:  cmd.op = OP_ACC;
         S_IQ_END: cmd.op = OP_IQ_DONE;
         S_SEC_M1: cmd.op = OP_MUL_AFB;
         S_SEC_M2: cmd.op = OP_MUL_BFA;
         S_SEC_D:  cmd.op = OP_DIV_SEC;
         S_SEC_W:  cmd.op = OP_WB_S;
         S_DECIDE: cmd.op = OP_DECIDE;
         S_EMIT:   cmd.op = status.slot_free ? OP_EMIT : OP_NONE;
         default:  cmd.op = OP_NONE;
      endcase
   end

   // divider finishes only while we wait on it
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == S_IQ_W1 || state_ff == S_IQ_W2 ||
                           state_ff == S_SEC_W))
      else $error("divider done outside a wait state");

   a_div_done_held: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> $past(state_ff) == state_ff)
      else $error("divider done without a full wait");

   a_term_range: assert property (@(posedge clock) disable iff (reset)
      term_ff <= TERM_LAST)
      else $error("interpolation term out of range");

endmodule

// File: rtl/brs_datapath.sv
// brs_datapath: search state, multiplier, operand selection and result word registers
// depends on brs_pkg and brs_div
module brs_datapath
   import brs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output status_type         status,
   input  logic               req_mode,
   input  logic signed [31:0] req_end_a,
   input  logic signed [31:0] req_end_b,
   input  logic signed [31:0] req_f_end_a,
   input  logic signed [31:0] req_f_end_b,
   input  logic signed [31:0] req_f_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_point,
   input  logic               csr_valid,
   input  logic [30:0]        csr_tolerance
);

   function automatic logic [32:0] mag33(input logic signed [32:0] v);
      logic [32:0] r;
      r = v[32] ? 33'(-v) : 33'(v);
      return r;
   endfunction

   logic [30:0] tol_ff;
   logic signed [31:0] a_ff, b_ff, c_ff, d_ff, fa_ff, fb_ff, fc_ff, trial_ff;
   logic um_ff, srch_ff;
   logic in_mode_ff;
   logic signed [31:0] in_ea_ff, in_eb_ff, in_fea_ff, in_feb_ff, in_fv_ff;
   logic signed [31:0] t1_ff, t2_ff, s_ff;
   logic signed [33:0] acc_ff;
   logic signed [63:0] prod_ff, p1_ff;
   logic bis_ff;
   logic [1:0] res_kind_ff;
   logic signed [31:0] res_point_ff;
   logic rsp_valid_ff;
   logic [1:0] rsp_kind_ff;
   logic signed [31:0] rsp_point_ff;

   logic start_bad, slot_free;
   logic signed [31:0] sw_a, sw_b, sw_fa, sw_fb;
   logic [32:0] ab_mag;
   logic done_now, iq_ok, sec_ok;
   logic signed [31:0] own, oth1, oth2, x_term;
   logic div_start, div_done;
   logic signed [64:0] div_num;
   logic signed [32:0] div_den;
   logic signed [31:0] div_q;
   logic signed [31:0] mul_x, mul_y;
   logic signed [47:0] qm48;
   logic signed [31:0] qm;
   logic signed [34:0] sum3, quart, s_q, s_b;
   logic signed [32:0] mid2, mid;
   logic [32:0] gap_mag, sb_mag;
   logic bis_new;
   logic signed [31:0] s_new;

   always_comb begin
      start_bad = (in_fea_ff > 32'sd0 && in_feb_ff > 32'sd0) ||
                  (in_fea_ff < 32'sd0 && in_feb_ff < 32'sd0);
      slot_free = !rsp_valid_ff || !rsp_stall;

      // keep b as the end with the smaller residual
      if (mag33(33'(fb_ff)) > mag33(33'(fa_ff))) begin
         sw_a = b_ff; sw_b = a_ff; sw_fa = fb_ff; sw_fb = fa_ff;
      end else begin
         sw_a = a_ff; sw_b = b_ff; sw_fa = fa_ff; sw_fb = fb_ff;
      end

      ab_mag   = mag33(33'(a_ff) - 33'(b_ff));
      done_now = !(ab_mag > {2'b00, tol_ff} && fb_ff != 32'sd0);
      iq_ok    = fa_ff != fc_ff && fb_ff != fc_ff && fa_ff != fb_ff;
      sec_ok   = fb_ff != fa_ff;

      case (cmd.term)
         2'd0:    begin own = fa_ff; oth1 = fb_ff; oth2 = fc_ff; x_term = a_ff; end
         2'd1:    begin own = fb_ff; oth1 = fa_ff; oth2 = fc_ff; x_term = b_ff; end
         default: begin own = fc_ff; oth1 = fa_ff; oth2 = fb_ff; x_term = c_ff; end
      endcase

      div_start = 1'b0;
      div_num   = $signed({{17{oth1[31]}}, oth1, 16'h0000});
      div_den   = 33'(own) - 33'(oth1);
      case (cmd.op)
         OP_DIV_IQ1: div_start = 1'b1;
         OP_DIV_IQ2: begin
            div_start = 1'b1;
            div_num   = $signed({{17{oth2[31]}}, oth2, 16'h0000});
            div_den   = 33'(own) - 33'(oth2);
         end
         OP_DIV_SEC: begin
            div_start = 1'b1;
            div_num   = 65'(p1_ff) - 65'(prod_ff);
            div_den   = 33'(fb_ff) - 33'(fa_ff);
         end
         default: ;
      endcase

      case (cmd.op)
         OP_MUL_X:   begin mul_x = x_term; mul_y = t1_ff; end
         OP_MUL_AFB: begin mul_x = a_ff;   mul_y = fb_ff; end
         OP_MUL_BFA: begin mul_x = b_ff;   mul_y = fa_ff; end
         default:    begin mul_x = t1_ff;  mul_y = t2_ff; end
      endcase

      // q16 product, truncated toward zero
      qm48 = prod_ff[63] ? 48'((prod_ff + 64'sd65535) >>> 16) : 48'(prod_ff >>> 16);
      qm   = sat32(66'(qm48));

      sum3  = 35'(a_ff) + 35'(a_ff) + 35'(a_ff) + 35'(b_ff);
      quart = sum3[34] ? ((sum3 + 35'sd3) >>> 2) : (sum3 >>> 2);
      s_q   = 35'(s_ff) - quart;
      s_b   = 35'(s_ff) - 35'(b_ff);
      gap_mag = um_ff ? mag33(33'(b_ff) - 33'(c_ff)) : mag33(33'(c_ff) - 33'(d_ff));
      sb_mag = mag33(33'(s_ff) - 33'(b_ff));
      bis_new = bis_ff;
      if (!((s_q < 0 && s_b > 0) || (s_q > 0 && s_b < 0)) && s_q != 0 && s_b != 0)
         bis_new = 1'b1;
      if (sb_mag >= (gap_mag >> 1)) bis_new = 1'b1;
      if (gap_mag < {2'b00, tol_ff}) bis_new = 1'b1;
      mid2  = 33'(a_ff) + 33'(b_ff);
      mid   = mid2[32] ? ((mid2 + 33'sd1) >>> 1) : (mid2 >>> 1);
      s_new = bis_new ? mid[31:0] : s_ff;
   end

   assign status.bad_item  = (in_mode_ff == MODE_START) ? start_bad : !srch_ff;
   assign status.done_now  = done_now;
   assign status.iq_ok     = iq_ok;
   assign status.sec_ok    = sec_ok;
   assign status.div_done  = div_done;
   assign status.slot_free = slot_free;

   brs_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_tolerance;
      end
   end

   // search state
   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0; b_ff <= '0; c_ff <= '0; d_ff <= '0;
         fa_ff <= '0; fb_ff <= '0; fc_ff <= '0; trial_ff <= '0;
         um_ff <= 1'b1;
         srch_ff <= 1'b0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               if (in_mode_ff == MODE_START) begin
                  if (start_bad) begin
                     srch_ff <= 1'b0;
                  end else begin
                     a_ff <= in_ea_ff; b_ff <= in_eb_ff;
                     fa_ff <= in_fea_ff; fb_ff <= in_feb_ff;
                  end
               end else if (srch_ff) begin
                  d_ff <= c_ff;
                  c_ff <= b_ff;
                  fc_ff <= fb_ff;
                  if ((fa_ff < 32'sd0 && in_fv_ff > 32'sd0) ||
                      (fa_ff > 32'sd0 && in_fv_ff < 32'sd0)) begin
                     b_ff <= trial_ff; fb_ff <= in_fv_ff;
                  end else begin
                     a_ff <= trial_ff; fa_ff <= in_fv_ff;
                  end
               end
            end
            OP_SWAP: begin
               a_ff <= sw_a; b_ff <= sw_b; fa_ff <= sw_fa; fb_ff <= sw_fb;
               if (in_mode_ff == MODE_START) begin
                  c_ff <= sw_a; d_ff <= sw_a; fc_ff <= sw_fa;
                  um_ff <= 1'b1;
               end
            end
            OP_CHECK: if (done_now) srch_ff <= 1'b0;
            OP_DECIDE: begin
               um_ff <= bis_new;
               trial_ff <= s_new;
               srch_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // working registers and result word
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_CAPTURE: begin
            in_mode_ff <= req_mode;
            in_ea_ff <= req_end_a; in_eb_ff <= req_end_b;
            in_fea_ff <= req_f_end_a; in_feb_ff <= req_f_end_b;
            in_fv_ff <= req_f_value;
         end
         OP_LOAD: begin
            res_kind_ff <= KIND_ERROR;
            res_point_ff <= '0;
         end
         OP_CHECK: begin
            acc_ff <= '0;
            s_ff <= b_ff;
            bis_ff <= !iq_ok && !sec_ok;
            res_kind_ff <= KIND_ROOT;
            res_point_ff <= b_ff;
         end
         OP_WB_T1:  if (div_done) t1_ff <= div_q;
         OP_WB_T2:  if (div_done) t2_ff <= div_q;
         OP_WB_S:   if (div_done) s_ff <= div_q;
         OP_MUL_T, OP_MUL_X, OP_MUL_AFB: prod_ff <= mul_x * mul_y;
         OP_MUL_BFA: begin
            p1_ff <= prod_ff;
            prod_ff <= mul_x * mul_y;
         end
         OP_MUL_WB:  t1_ff <= qm;
         OP_ACC:     acc_ff <= acc_ff + 34'(qm);
         OP_IQ_DONE: s_ff <= sat32(66'(acc_ff));
         OP_DECIDE: begin
            res_kind_ff <= KIND_QUERY;
            res_point_ff <= s_new;
         end
         OP_EMIT: begin
            rsp_kind_ff <= res_kind_ff;
            rsp_point_ff <= res_point_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_EMIT) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind  = rsp_kind_ff;
   assign rsp_point = rsp_point_ff;

endmodule

// File: rtl/brent_root_search_top.sv
// brent_root_search_top: brent root search engine, function evaluated outside
// depends on brs_pkg, brs_ctrl, brs_datapath (with brs_div)
//
//   channel | dir | handshake            | word
//   req     | in  | req_valid/req_stall  | mode, end_a, end_b, f_end_a, f_end_b, f_value
//   rsp     | out | rsp_valid/rsp_stall  | kind, point
//   csr     | in  | csr_valid/csr_ready  | tolerance
//
// one word in flight
// each division holds the shared divider through start, 64 iterations and done;
// a secant step needs one division, interpolation six
// a new word is taken once the previous result sits in the output register;
// a stalled output holds the engine in the emit state
// reset is synchronous, active high; tolerance resets to 66
// csr_ready is always high
module brent_root_search_top
   import brs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_mode,
   input  logic signed [31:0] req_end_a,
   input  logic signed [31:0] req_end_b,
   input  logic signed [31:0] req_f_end_a,
   input  logic signed [31:0] req_f_end_b,
   input  logic signed [31:0] req_f_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_kind,
   output logic signed [31:0] rsp_point,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [30:0]        csr_tolerance
);

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   brs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   brs_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_mode      (req_mode),
      .req_end_a     (req_end_a),
      .req_end_b     (req_end_b),
      .req_f_end_a   (req_f_end_a),
      .req_f_end_b   (req_f_end_b),
      .req_f_value   (req_f_value),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_kind      (rsp_kind),
      .rsp_point     (rsp_point),
      .csr_valid     (csr_valid & csr_ready),
      .csr_tolerance (csr_tolerance)
   );

endmodule

// File: tb/sv/tb_brent_root_search_top.sv
// tb_brent_root_search_top: self-checking bench for the brent root search engine
// drives starts and function values, predicts every result and compares kind and point
// depends on brs_pkg and brent_root_search_top
`timescale 1ns / 100ps

module tb_brent_root_search_top
   import brs_pkg::*;
();

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_mode;
   logic signed [31:0] req_end_a;
   logic signed [31:0] req_end_b;
   logic signed [31:0] req_f_end_a;
   logic signed [31:0] req_f_end_b;
   logic signed [31:0] req_f_value;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [1:0]         rsp_kind;
   logic signed [31:0] rsp_point;
   logic               csr_valid;
   logic               csr_ready;
   logic [30:0]        csr_tolerance;

   brent_root_search_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_end_a(req_end_a), .req_end_b(req_end_b),
      .req_f_end_a(req_f_end_a), .req_f_end_b(req_f_end_b), .req_f_value(req_f_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_kind(rsp_kind),
      .rsp_point(rsp_point),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_tolerance(csr_tolerance)
   );

   typedef logic signed [65:0] wide_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [31:0] point;
   } answer_type;

   typedef struct packed {
      logic               mode;
      logic signed [31:0] end_a;
      logic signed [31:0] end_b;
      logic signed [31:0] f_end_a;
      logic signed [31:0] f_end_b;
      logic signed [31:0] f_value;
      logic               known;
      logic [1:0]         kind;
      logic signed [31:0] point;
   } row_type;

   answer_type pending_answers[$];
   int         mismatches = 0;
   logic       quiet = 1'b0;

   // search state mirror
   logic [30:0]        tol_q;
   logic signed [31:0] x_a, x_b, x_c, x_d, y_a, y_b, y_c, trial;
   logic               mid_used, running;
   answer_type         last_answer;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic signed [31:0] clip(input wide_type v);
      if (v > 66'sd2147483647) return 32'sh7FFF_FFFF;
      if (v < -66'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   function automatic wide_type fx_mul(input wide_type x, input wide_type y);
      wide_type p;
      p = (x * y) / 66'sd65536;
      return wide_type'(clip(p));
   endfunction

   function automatic wide_type fx_div(input wide_type n, input wide_type d);
      wide_type p;
      p = (n * 66'sd65536) / d;
      return wide_type'(clip(p));
   endfunction

   function automatic wide_type absv(input wide_type v);
      return v < 0 ? -v : v;
   endfunction

   function automatic logic opposite(input wide_type x, input wide_type y);
      return (x < 0 && y > 0) || (x > 0 && y < 0);
   endfunction

   task automatic order_ends;
      logic signed [31:0] t;
      if (absv(wide_type'(y_b)) > absv(wide_type'(y_a))) begin
         t = x_a; x_a = x_b; x_b = t;
         t = y_a; y_a = y_b; y_b = t;
      end
   endtask

   task automatic next_point;
      wide_type a, b, c, fa, fb, fc, s, q, tol, gap;
      logic     bisect;
      a = x_a; b = x_b; c = x_c; fa = y_a; fb = y_b; fc = y_c;
      tol = wide_type'({35'd0, tol_q});
      bisect = 1'b0;
      if (!(absv(a - b) > tol && fb != 0)) begin
         running = 1'b0;
         last_answer = '{KIND_ROOT, x_b};
         return;
      end
      if (fa != fc && fb != fc && fa != fb) begin
         s = fx_mul(a, fx_mul(fx_div(fb, fa - fb), fx_div(fc, fa - fc)))
           + fx_mul(b, fx_mul(fx_div(fa, fb - fa), fx_div(fc, fb - fc)))
           + fx_mul(c, fx_mul(fx_div(fa, fc - fa), fx_div(fb, fc - fb)));
         s = wide_type'(clip(s));
      end else if (fb != fa) begin
         s = wide_type'(clip((a * fb - b * fa) / (fb - fa)));
      end else begin
         s = b;
         bisect = 1'b1;
      end
      q = (3 * a + b) / 4;
      if (!opposite(s - q, s - b) && s != q && s != b) bisect = 1'b1;
      gap = mid_used ? absv(b - c) : absv(c - wide_type'(x_d));
      if (absv(s - b) >= gap / 2) bisect = 1'b1;
      if (gap < tol) bisect = 1'b1;
      if (bisect) s = (a + b) / 2;
      mid_used = bisect;
      trial = s[31:0];
      running = 1'b1;
      last_answer = '{KIND_QUERY, s[31:0]};
   endtask

   // updates the mirror for one accepted word and leaves the answer in last_answer
   task automatic solver_step(input row_type r);
      if (r.mode == MODE_START) begin
         if ((r.f_end_a > 0 && r.f_end_b > 0) || (r.f_end_a < 0 && r.f_end_b < 0)) begin
            running = 1'b0;
            last_answer = '{KIND_ERROR, 32'sd0};
            return;
         end
         x_a = r.end_a; x_b = r.end_b; y_a = r.f_end_a; y_b = r.f_end_b;
         order_ends();
         x_c = x_a; x_d = x_a; y_c = y_a;
         mid_used = 1'b1;
         next_point();
      end else if (!running) begin
         last_answer = '{KIND_ERROR, 32'sd0};
      end else begin
         x_d = x_c; x_c = x_b; y_c = y_b;
         if (opposite(wide_type'(y_a), wide_type'(r.f_value))) begin
            x_b = trial; y_b = r.f_value;
         end else begin
            x_a = trial; y_a = r.f_value;
         end
         order_ends();
         next_point();
      end
   endtask

   // valid stays high after acceptance; the caller drives the next word or drops valid
   // at the same falling edge
   task automatic send_word(input row_type r);
      if (!quiet && $urandom_range(99) < 6) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_mode    <= r.mode;
      req_end_a   <= r.end_a;
      req_end_b   <= r.end_b;
      req_f_end_a <= r.f_end_a;
      req_f_end_b <= r.f_end_b;
      req_f_value <= r.f_value;
      do @(posedge clock); while (req_stall);
      solver_step(r);
      pending_answers.push_back(r.known ? answer_type'({r.kind, r.point}) : last_answer);
      @(negedge clock);
   endtask

   task automatic write_tolerance(input logic [30:0] v);
      req_valid <= 1'b0;
      wait (pending_answers.size() == 0);
      repeat (12) @(negedge clock);
      csr_valid     <= 1'b1;
      csr_tolerance <= v;
      do @(posedge clock); while (!csr_ready);
      tol_q = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // test functions evaluated at a query point: linear, signed square, step
   function automatic logic signed [31:0] eval_f(input int shape, input wide_type slope,
                                                 input wide_type root, input wide_type x);
      wide_type d;
      d = x - root;
      case (shape)
         0: return clip((slope * d) / 66'sd65536);
         1: return clip((d * absv(d)) / 66'sd65536 + slope / 64);
         default: return d > 0 ? slope[31:0] : (d < 0 ? -slope[31:0] : 32'sd0);
      endcase
   endfunction

   // rsp side: random stall and comparison with the oldest expectation
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !quiet && ($urandom_range(99) < 6);
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $error("result word with nothing expected: kind %0d point %0d", rsp_kind,
                   rsp_point);
            mismatches++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_kind);
               mismatches++;
            end
            if (rsp_point !== want.point) begin
               $error("point: expected %0d, actual %0d", want.point, rsp_point);
               mismatches++;
            end
         end
      end
   end

   row_type directed[$];

   initial begin
      row_type  r;
      int       sent, steps, shape, phase;
      wide_type root, slope, lo, hi, span;
      logic [30:0] tol_set [5];

      reset = 1'b1; req_valid = 1'b0; req_mode = 1'b0;
      req_end_a = '0; req_end_b = '0; req_f_end_a = '0; req_f_end_b = '0;
      req_f_value = '0; csr_valid = 1'b0; csr_tolerance = '0;
      tol_q = TOL_RESET;
      x_a = 0; x_b = 0; x_c = 0; x_d = 0; y_a = 0; y_b = 0; y_c = 0; trial = 0;
      mid_used = 1'b1; running = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // mode, a, b, fa, fb, fv, known, kind, point
      directed.push_back('{MODE_VALUE, 0, 0, 0, 0, 32'sd12345, 1, KIND_ERROR, 0});
      directed.push_back('{MODE_START, 0, 65536, 65536, 131072, 0, 1, KIND_ERROR, 0});
      directed.push_back('{MODE_START, -65536, 65536, -65536, 0, 0, 1, KIND_ROOT, 65536});
      directed.push_back('{MODE_START, 700, 900, 0, 5, 0, 1, KIND_ROOT, 700});
      directed.push_back('{MODE_START, 100, 130, -5, 7, 0, 1, KIND_ROOT, 100});
      directed.push_back('{MODE_START, 32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                           32'sh7FFF_FFFF, 0, 0, 0, 0});
      directed.push_back('{MODE_VALUE, 0, 0, 0, 0, 32'sh7FFF_FFFF, 0, 0, 0});
      directed.push_back('{MODE_VALUE, 0, 0, 0, 0, 32'sh8000_0000, 0, 0, 0});
      directed.push_back('{MODE_VALUE, 0, 0, 0, 0, -32'sd1, 0, 0, 0});
      directed.push_back('{MODE_START, -65536, 3 * 65536, -65536, 65536, 0, 0, 0, 0});
      directed.push_back('{MODE_VALUE, 0, 0, 0, 0, -65536, 0, 0, 0});
      directed.push_back('{MODE_VALUE, 0, 0, 0, 0, 32768, 0, 0, 0});
      directed.push_back('{MODE_VALUE, 0, 0, 0, 0, 1000, 0, 0, 0});
      directed.push_back('{MODE_START, 0, 4 * 65536, -2 * 65536, 65536, 0, 0, 0, 0});
      directed.push_back('{MODE_START, 0, 10 * 65536, -65536, 65536, 0, 0, 0, 0});
      directed.push_back('{MODE_VALUE, 0, 0, 0, 0, 0, 0, 0, 0});
      directed.push_back('{MODE_VALUE, 0, 0, 0, 0, 0, 1, KIND_ERROR, 0});

      write_tolerance(TOL_RESET);
      foreach (directed[i]) send_word(directed[i]);

      tol_set = '{31'd0, 31'h7FFF_FFFF, 31'd1, 31'd66, 31'd4000};
      sent = 0;
      phase = 0;
      while (sent < 1800) begin
         if (sent >= phase * 300) begin
            write_tolerance(phase < 5 ? tol_set[phase] : 31'($urandom_range(0, 20000)));
            phase++;
         end
         quiet = (sent >= 700 && sent < 1000);
         if ($urandom_range(9) < 2) begin
            // noise: arbitrary words, starts with random end signs and stray values
            r = '0;
            r.mode = $urandom_range(1);
            r.end_a = $urandom; r.end_b = $urandom;
            r.f_end_a = $urandom; r.f_end_b = $urandom; r.f_value = $urandom;
            send_word(r);
            sent++;
         end else begin
            shape = $urandom_range(2);
            root  = $signed(32'($urandom_range(0, 32'h3FFF_FFFF))) - 66'sh2000_0000;
            slope = $urandom_range(8, 4 * 65536);
            if ($urandom_range(1)) slope = -slope;
            span  = $urandom_range(9) == 0 ? $urandom_range(1, 32'h3FFF_FFFF)
                                           : $urandom_range(1, 32'h000F_FFFF);
            lo = root - $signed(66'(span));
            hi = root + $signed(66'($urandom_range(1, span)));
            r = '0;
            r.mode = MODE_START;
            if ($urandom_range(1)) begin
               r.end_a = lo[31:0]; r.end_b = hi[31:0];
            end else begin
               r.end_a = hi[31:0]; r.end_b = lo[31:0];
            end
            r.f_end_a = eval_f(shape, slope, root, r.end_a);
            r.f_end_b = eval_f(shape, slope, root, r.end_b);
            send_word(r);
            sent++;
            steps = 0;
            while (running && steps < 60 && sent < 1800) begin
               r.mode = MODE_VALUE;
               r.f_value = eval_f(shape, slope, root, trial);
               if ($urandom_range(49) == 0) r.f_value = $urandom;
               send_word(r);
               sent++;
               steps++;
            end
         end
      end

      req_valid <= 1'b0;
      wait (pending_answers.size() == 0);
      repeat (600) @(posedge clock);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

// File: brent_root_search_top.f
rtl/brs_pkg.sv
rtl/brs_div.sv
rtl/brs_ctrl.sv
rtl/brs_datapath.sv
rtl/brent_root_search_top.sv
tb/sv/tb_brent_root_search_top.sv
